// File: hw/rtl/lbpg_pkg.sv
// Shared types, mode codes and SOS timing table for the LED blink pattern generator.
package lbpg_pkg;

	localparam int MODE_BITS   = 3;
	localparam int PERIOD_BITS = 12;
	localparam int SOS_MAX     = 32;
	localparam int SOS_IDX_W   = 5;

	localparam logic [MODE_BITS-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_SOLID  = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_FAST   = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_SLOW   = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_DOUBLE = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_TRIPLE = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_SOS    = 3'd6;

	localparam logic [PERIOD_BITS-1:0] PER_FAST   = 12'd200;
	localparam logic [PERIOD_BITS-1:0] PER_SLOW   = 12'd2000;
	localparam logic [PERIOD_BITS-1:0] PER_DOUBLE = 12'd1600;
	localparam logic [PERIOD_BITS-1:0] PER_TRIPLE = 12'd2000;
	localparam logic [PERIOD_BITS-1:0] ON_FAST    = 12'd100;
	localparam logic [PERIOD_BITS-1:0] ON_SLOW    = 12'd1000;
	localparam logic [PERIOD_BITS-1:0] BURST_LEN  = 12'd200;

	// On/off durations in ms; even steps are lit.
	localparam logic [PERIOD_BITS-1:0] SOS_DUR [SOS_MAX] = '{
		12'd100, 12'd100, 12'd100, 12'd100, 12'd100, 12'd300,
		12'd300, 12'd100, 12'd300, 12'd100, 12'd300, 12'd300,
		12'd100, 12'd100, 12'd100, 12'd100, 12'd100, 12'd1000,
		12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
		12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
	};

	// Configuration path to the front and back parts.
	typedef struct packed {
		logic                 restart;
		logic [MODE_BITS-1:0] new_mode;
		logic [MODE_BITS-1:0] mode;
	} ctrl_t;

	// Queue status toward the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic int sos_total(input int steps);
		int sum;
		sum = 0;
		for (int i = 0; i < SOS_MAX; i++) begin
			if (i < steps) sum += int'(SOS_DUR[i]);
		end
		return sum;
	endfunction

endpackage

// File: hw/rtl/led_blink_pattern_generator.sv
// Top level of the LED blink pattern generator with SOS pattern.
//
// Usage: each transaction on the s_ channel carries a millisecond timestamp
// (s_tdata, low TIME_BITS bits). For every input transaction exactly one
// result leaves on the m_ channel: m_tdata[0] is the LED level, m_tdata[1]
// flags that the level differs from the level held before the item.
// The cfg channel writes the 3-bit mode (0 off, 1 solid, 2 fast, 3 slow,
// 4 double, 5 triple, 6 SOS); cfg_ready is always high. Writing a new mode
// restarts the pattern, forces the level (on for solid, off otherwise), and
// the next timestamp becomes the new origin. Write only while idle.
// Each item goes into the queue, through the bit-serial modulo by the
// pattern period, an evaluate step, in SOS mode a walk of up to SOS_STEPS
// table entries, and into the output register. The single modulo unit in
// the back part takes a new item only once the last one has left for the
// output register.
// A two-entry queue lets timestamps be accepted while the back part works;
// when the receiver stalls the result holds in the output register and the
// queue fills, then s_tready drops. Reset clears the mode to off, the level
// to off and arms the start-time latch.
module led_blink_pattern_generator #(
	parameter int TIME_BITS = 32,
	parameter int SOS_STEPS = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // now_ms
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // led_on, led_changed
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lbpg_pkg::MODE_BITS-1:0]        cfg_data  // mode
);

	logic [lbpg_pkg::MODE_BITS-1:0] mode_q;
	lbpg_pkg::ctrl_t                ctrl;
	lbpg_pkg::q_stat_t              q_stat;
	logic                           q_push;
	logic                           q_pop;
	logic [TIME_BITS-1:0]           q_din;
	logic [TIME_BITS-1:0]           q_head;

	assign cfg_ready     = 1'b1;
	// Restart only when the written mode differs from the held one.
	assign ctrl.restart  = cfg_valid && cfg_ready && (cfg_data != mode_q);
	assign ctrl.new_mode = cfg_data;
	assign ctrl.mode     = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lbpg_pkg::MODE_OFF;
		end else if (ctrl.restart) begin
			mode_q <= cfg_data;
		end
	end

	lbpg_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.now_ms    (s_tdata[TIME_BITS-1:0]),
		.push      (q_push),
		.push_data (q_din),
		.q_stat    (q_stat)
	);

	lbpg_queue #(.WIDTH(TIME_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_din),
		.pop       (q_pop),
		.head      (q_head),
		.q_stat    (q_stat)
	);

	lbpg_back #(.TIME_BITS(TIME_BITS), .SOS_STEPS(SOS_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.q_stat    (q_stat),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// An accepted timestamp is in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !q_stat.empty)
		else $error("accepted timestamp missing from queue");

	// The back part never pops an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// Front never pushes into a full queue.
	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");
`endif

endmodule

// File: hw/rtl/lbpg_front.sv
// Front part: accepts timestamps, latches the start time and forms elapsed time.
module lbpg_front #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbpg_pkg::ctrl_t      ctrl,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_BITS-1:0] now_ms,
	output logic                 push,
	output logic [TIME_BITS-1:0] push_data,
	input  lbpg_pkg::q_stat_t    q_stat
);

	logic [TIME_BITS-1:0] start_q;
	logic                 pend_q;

	assign in_ready  = !q_stat.full;
	assign push      = in_valid && in_ready;
	// First item after reset or a restart is its own origin.
	assign push_data = pend_q ? '0 : (now_ms - start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			pend_q  <= 1'b1;
		end else if (ctrl.restart) begin
			pend_q <= 1'b1;
		end else if (push && pend_q) begin
			start_q <= now_ms;
			pend_q  <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/lbpg_queue.sv
// Two-entry queue of elapsed times between the front and back parts.
module lbpg_queue #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   head,
	output lbpg_pkg::q_stat_t  q_stat
);

	logic [WIDTH-1:0] e0_q;
	logic [WIDTH-1:0] e1_q;
	logic [1:0]       cnt_q;

	assign head         = e0_q;
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				e0_q <= push_data;
			end else begin
				e0_q <= e1_q;
				e1_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) e0_q <= push_data;
			else e1_q <= push_data;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hw/rtl/lbpg_back.sv
// Back part: bit-serial modulo by the pattern period, SOS table walk, result register.
module lbpg_back #(
	parameter int TIME_BITS = 32,
	parameter int SOS_STEPS = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbpg_pkg::ctrl_t      ctrl,
	input  lbpg_pkg::q_stat_t    q_stat,
	input  logic [TIME_BITS-1:0] head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_data
);

	localparam int PB       = lbpg_pkg::PERIOD_BITS;
	localparam int CNT_W    = $clog2(TIME_BITS);
	localparam int IDX_W    = $clog2(SOS_STEPS);
	localparam int SOS_TOT  = lbpg_pkg::sos_total(SOS_STEPS);
	localparam logic [PB-1:0] SOS_PER = (SOS_TOT == 0) ? PB'(1) : PB'(SOS_TOT);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_DIV  = 5'b00010,
		B_EVAL = 5'b00100,
		B_SCAN = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t              st_q;
	logic [TIME_BITS-1:0] div_q;
	logic [PB-1:0]        rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PB-1:0]        acc_q;
	logic                 nxt_q;
	logic                 led_q;

	logic [PB-1:0]         period;
	logic [PB:0]           rem_sh;
	logic [PB:0]           rem_sub;
	logic [PB-1:0]         acc_next;
	logic [lbpg_pkg::SOS_IDX_W-1:0] tbl_idx;
	logic                  out_free;
	logic                  blink_lvl;

	function automatic logic pattern(input logic [lbpg_pkg::MODE_BITS-1:0] m,
			input logic [PB-1:0] p);
		logic b1;
		logic b2;
		logic b3;
		b1 = (p < lbpg_pkg::BURST_LEN);
		b2 = (p >= 12'd400) && (p < 12'd600);
		b3 = (p >= 12'd800) && (p < 12'd1000);
		unique case (m)
			lbpg_pkg::MODE_SOLID:  return 1'b1;
			lbpg_pkg::MODE_FAST:   return p < lbpg_pkg::ON_FAST;
			lbpg_pkg::MODE_SLOW:   return p < lbpg_pkg::ON_SLOW;
			lbpg_pkg::MODE_DOUBLE: return b1 || b2;
			lbpg_pkg::MODE_TRIPLE: return b1 || b2 || b3;
			default:               return 1'b0;
		endcase
	endfunction

	always_comb begin
		unique case (ctrl.mode)
			lbpg_pkg::MODE_FAST:   period = lbpg_pkg::PER_FAST;
			lbpg_pkg::MODE_SLOW:   period = lbpg_pkg::PER_SLOW;
			lbpg_pkg::MODE_DOUBLE: period = lbpg_pkg::PER_DOUBLE;
			lbpg_pkg::MODE_TRIPLE: period = lbpg_pkg::PER_TRIPLE;
			lbpg_pkg::MODE_SOS:    period = SOS_PER;
			default:               period = PB'(1);
		endcase
	end

	// One quotient bit per cycle, MSB first.
	assign rem_sh   = {rem_q, div_q[TIME_BITS-1]};
	assign rem_sub  = rem_sh - {1'b0, period};
	assign tbl_idx  = lbpg_pkg::SOS_IDX_W'(idx_q);
	assign acc_next = acc_q + lbpg_pkg::SOS_DUR[tbl_idx];
	assign blink_lvl = pattern(ctrl.mode, rem_q);
	assign out_free = !out_valid || out_ready;
	assign pop      = (st_q == B_IDLE) && !q_stat.empty;

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				div_q <= head;
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				div_q <= div_q << 1;
				rem_q <= rem_sub[PB] ? rem_sh[PB-1:0] : rem_sub[PB-1:0];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			B_EVAL: begin
				idx_q <= '0;
				acc_q <= '0;
				// An empty SOS table keeps the level; the table walk overrides it otherwise.
				nxt_q <= (ctrl.mode == lbpg_pkg::MODE_SOS) ? led_q : blink_lvl;
			end
			B_SCAN: begin
				acc_q <= acc_next;
				idx_q <= idx_q + IDX_W'(1);
				if (rem_q < acc_next) nxt_q <= !idx_q[0];
				else if (idx_q == IDX_W'(SOS_STEPS - 1)) nxt_q <= led_q;
			end
			B_OUT: begin
				if (out_free) out_data <= {6'b0, nxt_q != led_q, nxt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			led_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == B_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (ctrl.restart) led_q <= (ctrl.new_mode == lbpg_pkg::MODE_SOLID);
			else if (st_q == B_OUT && out_free) led_q <= nxt_q;
			unique case (st_q)
				B_IDLE: if (pop) st_q <= B_DIV;
				B_DIV: if (cnt_q == CNT_W'(TIME_BITS - 1)) st_q <= B_EVAL;
				B_EVAL: begin
					if (ctrl.mode == lbpg_pkg::MODE_SOS && SOS_TOT != 0) st_q <= B_SCAN;
					else st_q <= B_OUT;
				end
				B_SCAN: begin
					if (rem_q < acc_next || idx_q == IDX_W'(SOS_STEPS - 1)) st_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
